### sv/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ZSN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zsn check failed");

// Next-cycle implication, disabled in reset
`define ZSN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zsn check failed");

`endif

### sv/zsn_pkg.sv
`default_nettype none
package zsn_pkg;

   localparam int MAX_LEN  = 64;
   localparam int IDX_W    = $clog2(MAX_LEN);
   localparam int CNT_W    = $clog2(MAX_LEN + 1);
   localparam int SAMP_W   = 16;
   localparam int SUM_W    = 22;
   localparam int OUT_W    = 16;
   localparam int FRAC_SH  = 12;
   // n*x - S
   localparam int D_W      = SUM_W + 1;
   localparam int SQ_W     = 2 * D_W;
   localparam int Q_W      = SQ_W + IDX_W;
   localparam int QN_RAW_W = Q_W + CNT_W;
   localparam int QN_W     = QN_RAW_W + (QN_RAW_W % 2);
   localparam int ROOT_W   = QN_W / 2;
   localparam int RS_W     = ROOT_W + 2;
   localparam int DN_W     = D_W + CNT_W;
   localparam int NUM_W    = DN_W + FRAC_SH;
   localparam int ITER_W   = $clog2(NUM_W + 1);
   localparam int MAX_POS  = 32767;
   localparam int MIN_MAG  = 32768;

   typedef struct packed {
      logic signed [SAMP_W-1:0] sample_value;
      logic                     last_sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normalized_value;
      logic                    last_result;
      logic                    overflowed;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]        n;
      logic signed [SUM_W-1:0] sum;
      logic                    ovf;
   } job_type;

   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         addr;
      logic signed [SAMP_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic active;
      logic emitting;
   } back_status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_P1_RD,
      BK_P1_D,
      BK_P1_SQ,
      BK_P1_ACC,
      BK_QN,
      BK_SQRT,
      BK_P2_RD,
      BK_P2_D,
      BK_P2_NUM,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage
`default_nettype wire

### sv/z_score_normalizer.sv
`default_nettype none
// Channel   Ports                          Handshake
// input     start, busy, req_word          taken when start && !busy
// result    rsp_valid, rsp_word            one-cycle strobe, cannot be held off
//
// Loading takes one word per cycle while busy is low. A word marked last closes
// the series; busy then stays high while the back end normalizes the n stored
// samples: it takes the job, runs the variance pass (read, deviation, square,
// accumulate per sample), forms Q*n, runs the bit-serial square root, and runs
// the output pass per sample (read, deviation, scale, 42 shift-subtract divide
// steps, emit). With zero deviation the divide steps are skipped.
// Reset is synchronous and clears the counters, queue and sequencer.
module z_score_normalizer import zsn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   mem_wr_type      mem_wr;
   logic            job_push, job_pop, q_empty;
   job_type         job_word, job_head;
   back_status_type status;
   logic            accept;

   // hold input while a series waits or is being normalized
   assign busy   = !q_empty || status.active;
   assign accept = start && !busy;

   zsn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .mem_wr   (mem_wr),
      .job_push (job_push),
      .job_word (job_word)
   );

   zsn_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_word),
      .pop       (job_pop),
      .head_word (job_head),
      .empty     (q_empty)
   );

   zsn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mem_wr    (mem_wr),
      .job_ready (!q_empty),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

### sv/zsn_front.sv
`default_nettype none
module zsn_front import zsn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire req_type    req_word,
   output mem_wr_type      mem_wr,
   output logic            job_push,
   output job_type         job_word
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        count_nx;
   logic signed [SUM_W-1:0] total_nx;
   logic                    ovf_nx;
   logic                    room;

   // store the word when there is room, flag a drop otherwise
   always_comb begin
      room     = (count_ff < CNT_W'(MAX_LEN));
      count_nx = count_ff;
      total_nx = total_ff;
      ovf_nx   = ovf_ff;
      if (room) begin
         count_nx = count_ff + CNT_W'(1);
         total_nx = total_ff + SUM_W'(req_word.sample_value);
      end else begin
         ovf_nx = 1'b1;
      end
      mem_wr.en   = accept && room;
      mem_wr.addr = count_ff[IDX_W-1:0];
      mem_wr.data = req_word.sample_value;
      job_push    = accept && req_word.last_sample;
      job_word.n   = count_nx;
      job_word.sum = total_nx;
      job_word.ovf = ovf_nx;
      count_in = count_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_word.last_sample) begin
            count_in = '0;
            total_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_nx;
            total_in = total_nx;
            ovf_in   = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
`default_nettype wire

### sv/zsn_job_queue.sv
`default_nettype none
module zsn_job_queue import zsn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_word,
   input  wire logic    pop,
   output job_type      head_word,
   output logic         empty
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   // two-entry FIFO of finished series
   always_comb begin
      empty     = (fill_ff == 2'd0);
      do_push   = push && (fill_ff != 2'd2);
      do_pop    = pop && !empty;
      head_word = slot_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

### sv/zsn_back.sv
`default_nettype none
module zsn_back import zsn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire mem_wr_type mem_wr,
   input  wire logic       job_ready,
   input  wire job_type    job_head,
   output logic            job_pop,
   output back_status_type status,
   output logic            rsp_valid,
   output rsp_type         rsp_word
);
`include "assert_macros.svh"

   logic signed [SAMP_W-1:0] mem [MAX_LEN];
   logic signed [SAMP_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;

   back_state_type           state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [QN_W-1:0]          v_ff, v_in;
   logic [RS_W-1:0]          srem_ff, srem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic [ROOT_W:0]          drem_ff, drem_in;

   logic signed [D_W-1:0]    d_calc;
   logic signed [DN_W-1:0]   dn_calc;
   logic [DN_W-1:0]          dn_mag;
   logic [RS_W-1:0]          s_cat, s_trial;
   logic [ROOT_W:0]          d_cat;
   logic                     last_idx;
   logic signed [OUT_W-1:0]  z_val;

   // sample memory: written by the front, read one word a cycle
   assign rd_addr = idx_ff[IDX_W-1:0];
   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
      rd_data_ff <= mem[rd_addr];
   end

   // datapath terms
   always_comb begin
      d_calc  = D_W'($signed({1'b0, job_ff.n}) * rd_data_ff) - D_W'(job_ff.sum);
      dn_calc = DN_W'(d_ff * $signed({1'b0, job_ff.n}));
      dn_mag  = dn_calc[DN_W-1] ? DN_W'(-dn_calc) : DN_W'(dn_calc);
      s_cat   = {srem_ff[RS_W-3:0], v_ff[QN_W-1 -: 2]};
      s_trial = {root_ff, 2'b01};
      d_cat   = {drem_ff[ROOT_W-1:0], num_ff[NUM_W-1]};
      last_idx = (idx_ff == job_ff.n - CNT_W'(1));
      // zero when the root is zero, else clamp quotient magnitude, apply sign
      if (root_ff == '0) begin
         z_val = '0;
      end else if (neg_ff) begin
         if (num_ff > NUM_W'(MIN_MAG)) z_val = OUT_W'(-MIN_MAG);
         else                          z_val = OUT_W'(-num_ff);
      end else begin
         if (num_ff > NUM_W'(MAX_POS)) z_val = OUT_W'(MAX_POS);
         else                          z_val = OUT_W'(num_ff);
      end
   end

   // sequencer: variance pass, root, then per-sample divide
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      q_in     = q_ff;
      v_in     = v_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      iter_in  = iter_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      drem_in  = drem_ff;
      job_pop  = 1'b0;
      rsp_valid = 1'b0;
      rsp_word.normalized_value = z_val;
      rsp_word.last_result      = last_idx;
      rsp_word.overflowed       = job_ff.ovf;
      case (state_ff)
         BK_IDLE: begin
            if (job_ready) begin
               job_pop  = 1'b1;
               job_in   = job_head;
               idx_in   = '0;
               q_in     = '0;
               state_in = BK_P1_RD;
            end
         end
         BK_P1_RD:  state_in = BK_P1_D;
         BK_P1_D: begin
            d_in     = d_calc;
            state_in = BK_P1_SQ;
         end
         BK_P1_SQ: begin
            sq_in    = SQ_W'(d_ff * d_ff);
            state_in = BK_P1_ACC;
         end
         BK_P1_ACC: begin
            q_in = q_ff + Q_W'(sq_ff);
            if (last_idx) begin
               state_in = BK_QN;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = BK_P1_RD;
            end
         end
         BK_QN: begin
            v_in     = QN_W'(q_ff * job_ff.n);
            srem_in  = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = BK_SQRT;
         end
         BK_SQRT: begin
            v_in = {v_ff[QN_W-3:0], 2'b00};
            if (s_cat >= s_trial) begin
               srem_in = s_cat - s_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = s_cat;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(ROOT_W - 1)) begin
               idx_in   = '0;
               state_in = BK_P2_RD;
            end
         end
         BK_P2_RD:  state_in = BK_P2_D;
         BK_P2_D: begin
            d_in     = d_calc;
            state_in = BK_P2_NUM;
         end
         BK_P2_NUM: begin
            neg_in   = dn_calc[DN_W-1];
            num_in   = {dn_mag, {FRAC_SH{1'b0}}};
            drem_in  = '0;
            iter_in  = '0;
            state_in = (root_ff == '0) ? BK_OUT : BK_DIV;
         end
         BK_DIV: begin
            if (d_cat >= {1'b0, root_ff}) begin
               drem_in = d_cat - {1'b0, root_ff};
               num_in  = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_in = d_cat;
               num_in  = {num_ff[NUM_W-2:0], 1'b0};
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(NUM_W - 1)) state_in = BK_OUT;
         end
         BK_OUT: begin
            rsp_valid = 1'b1;
            if (last_idx) begin
               state_in = BK_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = BK_P2_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      status.active   = (state_ff != BK_IDLE);
      status.emitting = rsp_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      q_ff    <= q_in;
      v_ff    <= v_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      num_ff  <= num_in;
      neg_ff  <= neg_in;
      drem_ff <= drem_in;
   end

   // checks
   `ZSN_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == BK_DIV, root_ff != '0)
   `ZSN_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_word.last_result, state_ff == BK_IDLE)
   `ZSN_ASSERT_IMPL(a_idx_in_range, clock, reset, state_ff != BK_IDLE, idx_ff < job_ff.n)
   `ZSN_ASSERT_IMPL(a_no_write_busy, clock, reset, mem_wr.en, state_ff == BK_IDLE)

endmodule
`default_nettype wire

### verif/tb_z_score_normalizer.sv
`default_nettype none
module tb_z_score_normalizer;
   import zsn_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   z_score_normalizer u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // predictor state
   logic signed [SAMP_W-1:0] series_buf [MAX_LEN];
   int unsigned              series_len;
   longint                   series_sum;
   bit                       series_dropped;

   rsp_type zscore_queue [$];
   int      error_count;
   int      idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // store a word; on last, queue the z-scores of the series
   task automatic predict_zscores(input req_type w);
      longint n, d, z;
      longint unsigned q, r;
      rsp_type e;
      if (series_len < MAX_LEN) begin
         series_buf[series_len] = w.sample_value;
         series_len++;
         series_sum += w.sample_value;
      end else begin
         series_dropped = 1'b1;
      end
      if (w.last_sample) begin
         n = series_len;
         q = 0;
         for (int i = 0; i < series_len; i++) begin
            d = n * longint'(series_buf[i]) - series_sum;
            q += longint'(d * d);
         end
         r = int_sqrt(q * n);
         for (int i = 0; i < series_len; i++) begin
            if (r == 0) begin
               z = 0;
            end else begin
               d = n * longint'(series_buf[i]) - series_sum;
               z = (d * n * 4096) / longint'(r);
               if (z > MAX_POS) z = MAX_POS;
               if (z < -MIN_MAG) z = -MIN_MAG;
            end
            e.normalized_value = z[OUT_W-1:0];
            e.last_result      = (i + 1 == series_len);
            e.overflowed       = series_dropped;
            zscore_queue = {zscore_queue, e};
         end
         series_len     = 0;
         series_sum     = 0;
         series_dropped = 1'b0;
      end
   endtask

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (zscore_queue.size() == 0) begin
            report_mismatch("unexpected word");
         end else begin
            e = zscore_queue.pop_front();
            if (rsp_word.normalized_value !== e.normalized_value)
               report_mismatch($sformatf("value %0d exp %0d",
                  rsp_word.normalized_value, e.normalized_value));
            if (rsp_word.last_result !== e.last_result)
               report_mismatch("last_result");
            if (rsp_word.overflowed !== e.overflowed)
               report_mismatch("overflowed");
         end
      end
   end

   // send one word, with random idle before it; start stays high after accept
   // until the next word or idle cycle replaces it
   task automatic send_word(input logic signed [SAMP_W-1:0] v, input bit last);
      req_type w;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      w.sample_value = v;
      w.last_sample  = last;
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_zscores(w);
   endtask

   task automatic send_series(input int len, input int mode);
      logic signed [SAMP_W-1:0] v;
      int base;
      base = $urandom_range(65535);
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: v = SAMP_W'($urandom);
            1: v = SAMP_W'(base + int'($urandom_range(64)) - 32);
            2: v = (i == 0) ? 16'sh7fff : 16'sh8000;
            default: v = base[15:0];
         endcase
         send_word(v, i == len - 1);
      end
   endtask

   task automatic test_directed();
      idle_pct = 0;
      // single sample: zero deviation
      send_series(1, 3);
      // constant series
      send_series(4, 3);
      // extremes, then a long skewed series
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh8000, 1'b1);
      for (int i = 0; i < 20; i++) send_word(16'sh0000, 1'b0);
      send_word(16'sh7fff, 1'b1);
   endtask

   task automatic test_overflow();
      // fill past capacity; the dropped last word still closes the series
      send_series(MAX_LEN + 3, 0);
      send_series(MAX_LEN, 1);
   endtask

   task automatic test_random(input int pct, input int words);
      int sent, len;
      idle_pct = pct;
      sent = 0;
      while (sent < words) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 2, 1)
                                        : $urandom_range(8, 1);
         send_series(len, $urandom_range(3) == 0 ? 1 : 0);
         sent += len;
      end
   endtask

   initial begin
      int spin;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      series_len = 0;
      series_sum = 0;
      series_dropped = 1'b0;
      error_count = 0;
      idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(0, 75);
      test_random(62, 75);
      test_random(23, 75);
      test_random(0, 75);
      start <= 1'b0;
      spin = 0;
      while (zscore_queue.size() != 0 && spin < 200000) begin
         @(posedge clock);
         spin++;
      end
      repeat (100) @(posedge clock);
      if (error_count == 0 && zscore_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
